>>> sv/integer_literal_parser_unit_assert.svh
// Assertion macros for the integer literal parser unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef INTEGER_LITERAL_PARSER_UNIT_ASSERT_SVH
`define INTEGER_LITERAL_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ILP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("integer literal parser check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ILP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integer literal parser check failed");

`endif

>>> sv/ilp_pkg.sv
// ----------------------------------------------------------------------------
// Integer literal parser package
// Shared widths, state encodings, the parser state record and digit decoding.
// ----------------------------------------------------------------------------
`default_nettype none

package ilp_pkg;

  // Width of the internal accumulator; results are sign-extended or
  // truncated from this width to the 32-bit output.
  localparam int VALUE_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int CHAR_WIDTH  = 8;

  // ASCII codes used by the parser.
  localparam logic [CHAR_WIDTH-1:0] CH_NUL      = 8'h00;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO     = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE     = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_MINUS    = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CH_LOWER_B  = 8'h62;
  localparam logic [CHAR_WIDTH-1:0] CH_LOWER_X  = 8'h78;
  localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A  = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A  = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UPPER_F  = 8'h46;
  localparam logic [CHAR_WIDTH-1:0] UPCASE_MASK = 8'hDF;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_FIRST  = 4'b0001,  // first character expected
    PH_PREFIX = 4'b0010,  // leading zero seen, prefix letter expected
    PH_SIGN   = 4'b0100,  // just after a 0b or 0x prefix
    PH_DIGITS = 4'b1000   // digits
  } phase_t;

  // Selected number base.
  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_BIN = 2'd1,
    RX_OCT = 2'd2,
    RX_HEX = 2'd3
  } radix_t;

  // Everything the parser carries from one character to the next.
  typedef struct packed {
    phase_t                 phase;
    radix_t                 radix;
    logic [VALUE_WIDTH-1:0] acc;
    logic                   neg;
    logic                   bad;
  } ilp_state_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } digit_t;

  // State after reset and after each terminating zero byte.
  localparam ilp_state_t STATE_INIT = '{
    phase: PH_FIRST,
    radix: RX_DEC,
    acc:   '0,
    neg:   1'b0,
    bad:   1'b0
  };

  // Value of a character as a digit of the given base.
  function automatic digit_t ilp_digit(input logic [CHAR_WIDTH-1:0] c, input radix_t rx);
    digit_t                d;
    logic [CHAR_WIDTH-1:0] u;
    logic [CHAR_WIDTH-1:0] dec_off;
    logic [CHAR_WIDTH-1:0] hex_off;
    d       = '0;
    u       = ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ? (c & UPCASE_MASK) : c;
    dec_off = c - CH_ZERO;
    hex_off = u - CH_UPPER_A + 8'd10;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      d.valid = 1'b1;
      d.val   = dec_off[3:0];
    end else if ((rx == RX_HEX) && (u >= CH_UPPER_A) && (u <= CH_UPPER_F)) begin
      d.valid = 1'b1;
      d.val   = hex_off[3:0];
    end
    // Range limits of the narrower bases.
    if ((rx == RX_BIN) && (d.val > 4'd1)) d.valid = 1'b0;
    if ((rx == RX_OCT) && (d.val > 4'd7)) d.valid = 1'b0;
    return d;
  endfunction

endpackage : ilp_pkg

`default_nettype wire

>>> sv/integer_literal_parser_unit.sv
// Result path: a terminating zero byte goes through the input register, then loads the
// result register, from which its result transfers.
// Throughput: one character per cycle; the input register and the result register
// decouple the two channels, so only a zero byte meeting a held result stalls, and the
// characters behind it wait with it.
// Reset (rst_n low, synchronous) clears the parser state and both valid flags.
// ----------------------------------------------------------------------------
// Integer literal parser unit
// Parses a zero-terminated ASCII integer literal one character per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_literal_parser_unit
  import ilp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [CHAR_WIDTH-1:0] in_char_code,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [OUT_WIDTH-1:0] out_value,
  output logic                       out_well_formed
);

  logic                  s1_valid_r;
  logic [CHAR_WIDTH-1:0] s1_char_r;
  ilp_state_t            state_r;
  ilp_state_t            state_nxt;
  logic                  out_valid_r;
  logic [OUT_WIDTH-1:0]  out_value_r;
  logic                  out_wf_r;
  logic [OUT_WIDTH-1:0]  res_value;
  logic                  res_wf;
  logic                  s1_is_end;
  logic                  out_free;
  logic                  s1_go;

  // Stage handshakes: only a terminating zero needs the result register.
  assign s1_is_end = (s1_char_r == CH_NUL);
  assign out_free  = !out_valid_r || out_ready;
  assign s1_go     = s1_valid_r && (!s1_is_end || out_free);
  assign in_ready  = !s1_valid_r || s1_go;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_char_r <= in_char_code;
    end
  end

  ilp_core u_core (
    .char_code   (s1_char_r),
    .cur         (state_r),
    .nxt         (state_nxt),
    .value       (res_value),
    .well_formed (res_wf)
  );

  // Parser state advances once per character leaving the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_INIT;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_is_end) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_is_end) begin
      out_value_r <= res_value;
      out_wf_r    <= res_wf;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = signed'(out_value_r);
  assign out_well_formed = out_wf_r;

endmodule : integer_literal_parser_unit

`default_nettype wire

>>> sv/ilp_core.sv
// ----------------------------------------------------------------------------
// Integer literal parser step logic
// Next state for one character, and the result value for a terminating zero.
// ----------------------------------------------------------------------------
`default_nettype none

module ilp_core
  import ilp_pkg::*;
(
  input  wire logic [CHAR_WIDTH-1:0] char_code,
  input  wire ilp_state_t            cur,
  output ilp_state_t                 nxt,
  output logic [OUT_WIDTH-1:0]       value,
  output logic                       well_formed
);

  radix_t                 radix_eff;
  logic                   take_sign;
  logic                   take_num;
  digit_t                 dig;
  logic [VALUE_WIDTH-1:0] acc_scaled;
  logic [VALUE_WIDTH-1:0] acc_new;
  logic [VALUE_WIDTH-1:0] res_raw;

  // Phase and base decisions for a nonzero character.
  always_comb begin
    nxt       = cur;
    radix_eff = cur.radix;
    take_sign = 1'b0;
    take_num  = 1'b0;
    unique case (cur.phase)
      PH_FIRST: begin
        if (char_code == CH_ZERO) begin
          nxt.phase = PH_PREFIX;
        end else begin
          radix_eff = RX_DEC;
          take_sign = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (char_code == CH_LOWER_B) begin
          radix_eff = RX_BIN;
          nxt.phase = PH_SIGN;
        end else if (char_code == CH_LOWER_X) begin
          radix_eff = RX_HEX;
          nxt.phase = PH_SIGN;
        end else begin
          radix_eff = RX_OCT;
          take_sign = 1'b1;
        end
      end
      PH_SIGN: begin
        take_sign = 1'b1;
      end
      PH_DIGITS: begin
        take_num = 1'b1;
      end
      default: begin
        take_num = 1'b1;
      end
    endcase
    nxt.radix = radix_eff;

    // The sign position takes a minus sign or falls through to a digit.
    if (take_sign) begin
      nxt.phase = PH_DIGITS;
      if (char_code == CH_MINUS) begin
        nxt.neg = 1'b1;
      end else begin
        take_num = 1'b1;
      end
    end

    if (take_num) begin
      if (!dig.valid) begin
        nxt.bad = 1'b1;
      end else if (!cur.bad) begin
        nxt.acc = acc_new;
      end
    end

    // A terminating zero returns the parser to its initial state.
    if (char_code == CH_NUL) begin
      nxt = STATE_INIT;
    end
  end

  // Digit decode and shift-add scaling by the base.
  always_comb begin
    dig = ilp_digit(char_code, radix_eff);
    unique case (radix_eff)
      RX_BIN:  acc_scaled = cur.acc << 1;
      RX_OCT:  acc_scaled = cur.acc << 3;
      RX_HEX:  acc_scaled = cur.acc << 4;
      RX_DEC:  acc_scaled = (cur.acc << 3) + (cur.acc << 1);
      default: acc_scaled = (cur.acc << 3) + (cur.acc << 1);
    endcase
    acc_new = acc_scaled + VALUE_WIDTH'(dig.val);
  end

  // Result for the end of a string.
  always_comb begin
    if (cur.bad) begin
      res_raw = '0;
    end else if (cur.neg) begin
      res_raw = '0 - cur.acc;
    end else begin
      res_raw = cur.acc;
    end
    value       = OUT_WIDTH'(signed'(res_raw));
    well_formed = !cur.bad;
  end

endmodule : ilp_core

`default_nettype wire

>>> sv/ilp_checker.sv
// ----------------------------------------------------------------------------
// Integer literal parser checker
// Port-level checks on the parser unit, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_literal_parser_unit_assert.svh"

module ilp_checker
  import ilp_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic [CHAR_WIDTH-1:0]  in_char_code,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic signed [OUT_WIDTH-1:0] out_value,
  input wire logic                   out_well_formed
);

  // A stalled result keeps its payload.
  `ILP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_value) && $stable(out_well_formed))

  // A stalled input character keeps its payload.
  `ILP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_char_code))

  // A malformed string always reports zero.
  `ILP_ASSERT_SAME(a_bad_is_zero, out_valid && !out_well_formed, out_value == '0)

  // No result is offered in the first cycle after reset.
  `ILP_ASSERT_SAME(a_reset_quiet, $rose(rst_n), !out_valid)

endmodule : ilp_checker

bind integer_literal_parser_unit ilp_checker u_ilp_checker (.*);

`default_nettype wire
